FILE: rtl/core/meb_pkg.sv
// ----------------------------------------------------------------------------
// Mandelbrot escape-time core package
// Widths, codes, shared types and saturation helper for the core.
// ----------------------------------------------------------------------------
package meb_pkg;

    // Plane values are signed Q4.28, zoom is unsigned Q16.16.
    localparam int DATA_W    = 32;
    localparam int FRAC_W    = 28;
    localparam int ZOOM_W    = 32;
    localparam int COORD_W   = 10;
    localparam int CNT_W     = 10;
    localparam int CFG_IDX_W = 4;

    // Picture sizes up to 4096 set the mapping widths.
    localparam int DEF_WIDTH  = 1024;
    localparam int DEF_HEIGHT = 1024;
    localparam int SIZE_W     = 13;
    localparam int DIFF_W     = 13;
    localparam int MAG_W      = 12;
    localparam int DEN_W      = ZOOM_W + SIZE_W - 1;

    // The mapping divides |pos - half| * 2^46 by zoom * size.
    localparam int MAP_SHIFT = 46;
    localparam int QUO_W     = 32;
    localparam int PRE_SHIFT = MAP_SHIFT - QUO_W;

    // Iteration datapath widths.
    localparam int PROD_W = 2 * DATA_W;
    localparam int SQ_W   = PROD_W - FRAC_W;
    localparam int SUM_W  = SQ_W + 2;

    localparam logic signed [DATA_W-1:0] DATA_MAX = {1'b0, {(DATA_W-1){1'b1}}};
    localparam logic signed [DATA_W-1:0] DATA_MIN = {1'b1, {(DATA_W-1){1'b0}}};
    localparam logic signed [SUM_W-1:0]  ESCAPE_BOUND = SUM_W'(4) <<< FRAC_W;

    localparam logic [ZOOM_W-1:0] ZOOM_RESET  = ZOOM_W'(65536);
    localparam logic [CNT_W-1:0]  LIMIT_RESET = CNT_W'(50);

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ZOOM     = 4'd0,
        CFG_SHIFT_RE = 4'd1,
        CFG_SHIFT_IM = 4'd2,
        CFG_LIMIT    = 4'd3
    } t_cfg_idx;

    // Top-level sequencer states.
    typedef enum logic [2:0] {
        S_IDLE,
        S_PREP,
        S_LOAD,
        S_DIV,
        S_MAP,
        S_ITER,
        S_DONE
    } t_state;

    // Iteration unit states.
    typedef enum logic [1:0] {
        IT_IDLE,
        IT_MUL,
        IT_ADD
    } t_iter_state;

    // One divide job as it travels around the cell ring.
    typedef struct packed {
        logic [DEN_W-1:0] rem;
        logic [DEN_W-1:0] den;
        logic [QUO_W-1:0] quo;
        logic             neg;
        logic             ovf;
    } t_div_job;

    // Status handed from the iteration unit to the sequencer.
    typedef struct packed {
        logic             done;
        logic [CNT_W-1:0] count;
        logic             escaped;
    } t_iter_res;

    // Clamp a wide signed sum to the signed data range.
    function automatic logic signed [DATA_W-1:0] sat_data(input logic signed [SUM_W-1:0] v);
        logic signed [DATA_W-1:0] res;
        if (v > SUM_W'(DATA_MAX)) begin
            res = DATA_MAX;
        end else if (v < SUM_W'(DATA_MIN)) begin
            res = DATA_MIN;
        end else begin
            res = v[DATA_W-1:0];
        end
        return res;
    endfunction

endpackage

FILE: rtl/core/meb_if.sv
// ----------------------------------------------------------------------------
// Mandelbrot core channel interfaces
// Valid/ready channels for pixel coordinates in and escape results out.
// ----------------------------------------------------------------------------
interface meb_pix_if;
    logic                         valid;
    logic                         ready;
    logic [meb_pkg::COORD_W-1:0]  pixel_col;
    logic [meb_pkg::COORD_W-1:0]  pixel_row;

    modport source (output valid, pixel_col, pixel_row, input ready);
    modport sink   (input valid, pixel_col, pixel_row, output ready);
endinterface

interface meb_res_if;
    logic                         valid;
    logic                         ready;
    logic [meb_pkg::COORD_W-1:0]  out_col;
    logic [meb_pkg::COORD_W-1:0]  out_row;
    logic [meb_pkg::CNT_W-1:0]    iteration_count;
    logic                         escaped;

    modport source (output valid, out_col, out_row, iteration_count, escaped, input ready);
    modport sink   (input valid, out_col, out_row, iteration_count, escaped, output ready);
endinterface

FILE: rtl/core/meb_div_cell.sv
// ----------------------------------------------------------------------------
// Mandelbrot divide cell
// One restoring-division step on the job handed over by the neighbor cell.
// ----------------------------------------------------------------------------
module meb_div_cell (
    input  logic              i_clk,
    input  logic              i_load,
    input  logic              i_run,
    input  meb_pkg::t_div_job i_init,
    input  meb_pkg::t_div_job i_prev,
    output meb_pkg::t_div_job o_job
);

    meb_pkg::t_div_job        r_job;
    meb_pkg::t_div_job        n_job;
    logic [meb_pkg::DEN_W:0]  rem_sh;
    logic                     fits;

    // Shift the partial remainder, subtract the divisor when it fits.
    always_comb begin
        rem_sh = {i_prev.rem, 1'b0};
        fits   = rem_sh >= {1'b0, i_prev.den};
        n_job  = r_job;
        if (i_load) begin
            n_job = i_init;
        end else if (i_run) begin
            n_job     = i_prev;
            n_job.rem = fits ? meb_pkg::DEN_W'(rem_sh - {1'b0, i_prev.den})
                             : rem_sh[meb_pkg::DEN_W-1:0];
            n_job.quo = {i_prev.quo[meb_pkg::QUO_W-2:0], fits};
        end
    end

    // Job payload register.
    always_ff @(posedge i_clk) begin
        r_job <= n_job;
    end

    assign o_job = r_job;

endmodule

FILE: rtl/core/meb_div_ring.sv
// ----------------------------------------------------------------------------
// Mandelbrot divide ring
// Two divide cells in a ring that carry the real and imaginary jobs.
// ----------------------------------------------------------------------------
module meb_div_ring (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_load,
    input  meb_pkg::t_div_job i_job_re,
    input  meb_pkg::t_div_job i_job_im,
    output logic              o_busy,
    output meb_pkg::t_div_job o_job_re,
    output meb_pkg::t_div_job o_job_im
);

    localparam int STEP_W = $clog2(meb_pkg::QUO_W + 1);

    logic [STEP_W-1:0] r_steps;
    logic [STEP_W-1:0] n_steps;
    logic              run;
    meb_pkg::t_div_job job_a;
    meb_pkg::t_div_job job_b;

    assign run = (r_steps != '0);

    // Step counter: one quotient bit per cycle for each job.
    always_comb begin
        n_steps = r_steps;
        if (i_load) begin
            n_steps = STEP_W'(meb_pkg::QUO_W);
        end else if (run) begin
            n_steps = r_steps - STEP_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_steps <= '0;
        end else begin
            r_steps <= n_steps;
        end
    end

    // The jobs swap cells every step; with an even number of steps each
    // job ends in the cell it was loaded into.
    meb_div_cell u_cell_a (
        .i_clk  (i_clk),
        .i_load (i_load),
        .i_run  (run),
        .i_init (i_job_re),
        .i_prev (job_b),
        .o_job  (job_a)
    );

    meb_div_cell u_cell_b (
        .i_clk  (i_clk),
        .i_load (i_load),
        .i_run  (run),
        .i_init (i_job_im),
        .i_prev (job_a),
        .o_job  (job_b)
    );

    assign o_busy   = run;
    assign o_job_re = job_a;
    assign o_job_im = job_b;

endmodule

FILE: rtl/core/meb_iter.sv
// ----------------------------------------------------------------------------
// Mandelbrot iteration unit
// Runs z = z^2 + c step by step, each step split into products, then sum and test.
// ----------------------------------------------------------------------------
module meb_iter (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_start,
    input  logic signed [meb_pkg::DATA_W-1:0]   i_c_re,
    input  logic signed [meb_pkg::DATA_W-1:0]   i_c_im,
    input  logic [meb_pkg::CNT_W-1:0]           i_limit,
    output meb_pkg::t_iter_res                  o_res
);

    meb_pkg::t_iter_state                r_state;
    meb_pkg::t_iter_state                n_state;
    logic signed [meb_pkg::DATA_W-1:0]   r_x;
    logic signed [meb_pkg::DATA_W-1:0]   r_y;
    logic [meb_pkg::CNT_W-1:0]           r_cnt;
    logic signed [meb_pkg::PROD_W-1:0]   r_xx_p;
    logic signed [meb_pkg::PROD_W-1:0]   r_yy_p;
    logic signed [meb_pkg::PROD_W-1:0]   r_xy_p;
    logic signed [meb_pkg::PROD_W-1:0]   prod_xx;
    logic signed [meb_pkg::PROD_W-1:0]   prod_yy;
    logic signed [meb_pkg::PROD_W-1:0]   prod_xy;
    logic signed [meb_pkg::SUM_W-1:0]    xx;
    logic signed [meb_pkg::SUM_W-1:0]    yy;
    logic signed [meb_pkg::SUM_W-1:0]    xy;
    logic signed [meb_pkg::DATA_W-1:0]   nx;
    logic signed [meb_pkg::DATA_W-1:0]   ny;
    logic                                stop;

    // Full products of the current point.
    assign prod_xx = r_x * r_x;
    assign prod_yy = r_y * r_y;
    assign prod_xy = r_x * r_y;

    // Dropping the low fraction bits of a signed product rounds toward minus infinity.
    always_comb begin
        xx   = meb_pkg::SUM_W'($signed(r_xx_p[meb_pkg::PROD_W-1:meb_pkg::FRAC_W]));
        yy   = meb_pkg::SUM_W'($signed(r_yy_p[meb_pkg::PROD_W-1:meb_pkg::FRAC_W]));
        xy   = meb_pkg::SUM_W'($signed(r_xy_p[meb_pkg::PROD_W-1:meb_pkg::FRAC_W]));
        stop = ((xx + yy) > meb_pkg::ESCAPE_BOUND) || (r_cnt >= i_limit);
        nx   = meb_pkg::sat_data(xx - yy + meb_pkg::SUM_W'(i_c_re));
        ny   = meb_pkg::sat_data((xy <<< 1) + meb_pkg::SUM_W'(i_c_im));
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            meb_pkg::IT_IDLE: begin
                if (i_start) begin
                    n_state = meb_pkg::IT_MUL;
                end
            end
            meb_pkg::IT_MUL: begin
                n_state = meb_pkg::IT_ADD;
            end
            meb_pkg::IT_ADD: begin
                n_state = stop ? meb_pkg::IT_IDLE : meb_pkg::IT_MUL;
            end
            default: begin
                n_state = meb_pkg::IT_IDLE;
            end
        endcase
    end

    // Status outputs.
    always_comb begin
        o_res.done    = (r_state == meb_pkg::IT_ADD) && stop;
        o_res.count   = r_cnt;
        o_res.escaped = (r_cnt < i_limit);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= meb_pkg::IT_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Point, count and product registers.
    always_ff @(posedge i_clk) begin
        if ((r_state == meb_pkg::IT_IDLE) && i_start) begin
            r_x   <= '0;
            r_y   <= '0;
            r_cnt <= '0;
        end
        if (r_state == meb_pkg::IT_MUL) begin
            r_xx_p <= prod_xx;
            r_yy_p <= prod_yy;
            r_xy_p <= prod_xy;
        end
        if ((r_state == meb_pkg::IT_ADD) && !stop) begin
            r_x   <= nx;
            r_y   <= ny;
            r_cnt <= r_cnt + meb_pkg::CNT_W'(1);
        end
    end

endmodule

FILE: rtl/core/mandelbrot_escape_time_core.sv
// ----------------------------------------------------------------------------
// Mandelbrot escape-time core
// Maps a pixel to the complex plane and counts iterations until escape.
// ----------------------------------------------------------------------------
// One pixel is worked on at a time. The time from one accepted pixel to the
// next grows with the iteration count n that the core returns. It is set by
// the iteration unit, which spends one state on the three products and one
// on the sum and escape test for every step, and by the two-cell divide ring,
// which produces one quotient bit per cycle for both axes, 32 bits each.
// A finished result waits in the output register while the next pixel is
// taken. Configuration writes are always accepted and must only be issued
// while no pixel is in flight.
module mandelbrot_escape_time_core #(
    parameter int WIDTH  = meb_pkg::DEF_WIDTH,
    parameter int HEIGHT = meb_pkg::DEF_HEIGHT
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    meb_pix_if.sink                           i_pix,
    meb_res_if.source                         o_res,
    input  logic                              i_cfg_valid,
    input  logic [meb_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [meb_pkg::DATA_W-1:0]        i_cfg_data,
    output logic                              o_cfg_ready
);

    localparam logic [meb_pkg::SIZE_W-1:0]        SIZE_RE = meb_pkg::SIZE_W'(WIDTH);
    localparam logic [meb_pkg::SIZE_W-1:0]        SIZE_IM = meb_pkg::SIZE_W'(HEIGHT);
    localparam logic signed [meb_pkg::DIFF_W-1:0] HALF_RE = meb_pkg::DIFF_W'(WIDTH / 2);
    localparam logic signed [meb_pkg::DIFF_W-1:0] HALF_IM = meb_pkg::DIFF_W'(HEIGHT / 2);

    // Configuration registers.
    logic [meb_pkg::ZOOM_W-1:0]          r_zoom;
    logic signed [meb_pkg::DATA_W-1:0]   r_shift_re;
    logic signed [meb_pkg::DATA_W-1:0]   r_shift_im;
    logic [meb_pkg::CNT_W-1:0]           r_limit;

    // Sequencer and pixel registers.
    meb_pkg::t_state                     r_state;
    meb_pkg::t_state                     n_state;
    logic [meb_pkg::COORD_W-1:0]         r_col;
    logic [meb_pkg::COORD_W-1:0]         r_row;
    logic [meb_pkg::DEN_W-1:0]           r_den_re;
    logic [meb_pkg::DEN_W-1:0]           r_den_im;
    logic signed [meb_pkg::DATA_W-1:0]   r_c_re;
    logic signed [meb_pkg::DATA_W-1:0]   r_c_im;
    logic [meb_pkg::CNT_W-1:0]           r_res_count;
    logic                                r_res_esc;

    // Output register.
    logic                                r_out_valid;
    logic                                n_out_valid;
    logic [meb_pkg::COORD_W-1:0]         r_out_col;
    logic [meb_pkg::COORD_W-1:0]         r_out_row;
    logic [meb_pkg::CNT_W-1:0]           r_out_count;
    logic                                r_out_esc;

    logic                                in_accept;
    logic                                div_load;
    logic                                div_busy;
    logic                                iter_start;
    logic                                out_load;
    logic [meb_pkg::ZOOM_W-1:0]          zoom_eff;
    logic [meb_pkg::DEN_W-1:0]           den_re;
    logic [meb_pkg::DEN_W-1:0]           den_im;
    meb_pkg::t_div_job                   init_re;
    meb_pkg::t_div_job                   init_im;
    meb_pkg::t_div_job                   job_re;
    meb_pkg::t_div_job                   job_im;
    meb_pkg::t_iter_res                  iter_res;

    // Build the initial divide job for one axis.
    function automatic meb_pkg::t_div_job make_job(
        input logic [meb_pkg::COORD_W-1:0]        pos,
        input logic signed [meb_pkg::DIFF_W-1:0]  half,
        input logic [meb_pkg::DEN_W-1:0]          den
    );
        logic signed [meb_pkg::DIFF_W-1:0] diff;
        logic [meb_pkg::DIFF_W-1:0]        mag;
        logic [meb_pkg::DEN_W-1:0]         num;
        meb_pkg::t_div_job                 job;
        diff     = $signed(meb_pkg::DIFF_W'(pos)) - half;
        mag      = diff[meb_pkg::DIFF_W-1] ? meb_pkg::DIFF_W'(-diff) : meb_pkg::DIFF_W'(diff);
        num      = meb_pkg::DEN_W'(mag[meb_pkg::MAG_W-1:0]) << meb_pkg::PRE_SHIFT;
        job.rem  = num;
        job.den  = den;
        job.quo  = '0;
        job.neg  = diff[meb_pkg::DIFF_W-1];
        // A quotient of 2^32 or more saturates whatever its low bits are.
        job.ovf  = (num >= den);
        return job;
    endfunction

    // Turn a finished quotient into a plane value and add the view shift.
    function automatic logic signed [meb_pkg::DATA_W-1:0] map_finish(
        input meb_pkg::t_div_job                  job,
        input logic signed [meb_pkg::DATA_W-1:0]  shift
    );
        logic                              big;
        logic signed [meb_pkg::DATA_W-1:0] val;
        big = job.ovf || job.quo[meb_pkg::QUO_W-1];
        if (job.neg) begin
            val = big ? meb_pkg::DATA_MIN : -$signed(job.quo);
        end else begin
            val = big ? meb_pkg::DATA_MAX : $signed(job.quo);
        end
        return meb_pkg::sat_data(meb_pkg::SUM_W'(val) + meb_pkg::SUM_W'(shift));
    endfunction

    // Configuration writes; unknown indexes are ignored.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_zoom     <= meb_pkg::ZOOM_RESET;
            r_shift_re <= '0;
            r_shift_im <= '0;
            r_limit    <= meb_pkg::LIMIT_RESET;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                meb_pkg::CFG_ZOOM:     r_zoom     <= i_cfg_data;
                meb_pkg::CFG_SHIFT_RE: r_shift_re <= $signed(i_cfg_data);
                meb_pkg::CFG_SHIFT_IM: r_shift_im <= $signed(i_cfg_data);
                meb_pkg::CFG_LIMIT:    r_limit    <= i_cfg_data[meb_pkg::CNT_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // Divisors for both axes; a zero zoom counts as the smallest step.
    assign zoom_eff = (r_zoom == '0) ? meb_pkg::ZOOM_W'(1) : r_zoom;
    assign den_re   = meb_pkg::DEN_W'(zoom_eff) * meb_pkg::DEN_W'(SIZE_RE);
    assign den_im   = meb_pkg::DEN_W'(zoom_eff) * meb_pkg::DEN_W'(SIZE_IM);
    assign init_re  = make_job(r_col, HALF_RE, r_den_re);
    assign init_im  = make_job(r_row, HALF_IM, r_den_im);

    assign in_accept = i_pix.valid && i_pix.ready;

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            meb_pkg::S_IDLE: begin
                if (in_accept) begin
                    n_state = meb_pkg::S_PREP;
                end
            end
            meb_pkg::S_PREP: begin
                n_state = meb_pkg::S_LOAD;
            end
            meb_pkg::S_LOAD: begin
                n_state = meb_pkg::S_DIV;
            end
            meb_pkg::S_DIV: begin
                if (!div_busy) begin
                    n_state = meb_pkg::S_MAP;
                end
            end
            meb_pkg::S_MAP: begin
                n_state = meb_pkg::S_ITER;
            end
            meb_pkg::S_ITER: begin
                if (iter_res.done) begin
                    n_state = meb_pkg::S_DONE;
                end
            end
            meb_pkg::S_DONE: begin
                if (!r_out_valid || o_res.ready) begin
                    n_state = meb_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = meb_pkg::S_IDLE;
            end
        endcase
    end

    // Sequencer outputs. The iteration unit starts together with the
    // register load of c; it first reads c in its sum state, after the products.
    always_comb begin
        i_pix.ready = (r_state == meb_pkg::S_IDLE);
        div_load    = (r_state == meb_pkg::S_LOAD);
        iter_start  = (r_state == meb_pkg::S_MAP);
        out_load    = (r_state == meb_pkg::S_DONE) && (!r_out_valid || o_res.ready);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= meb_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Pixel datapath registers.
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_col <= i_pix.pixel_col;
            r_row <= i_pix.pixel_row;
        end
        if (r_state == meb_pkg::S_PREP) begin
            r_den_re <= den_re;
            r_den_im <= den_im;
        end
        if (r_state == meb_pkg::S_MAP) begin
            r_c_re <= map_finish(job_re, r_shift_re);
            r_c_im <= map_finish(job_im, r_shift_im);
        end
        if ((r_state == meb_pkg::S_ITER) && iter_res.done) begin
            r_res_count <= iter_res.count;
            r_res_esc   <= iter_res.escaped;
        end
    end

    // Divide ring for both axes.
    meb_div_ring u_div_ring (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (div_load),
        .i_job_re (init_re),
        .i_job_im (init_im),
        .o_busy   (div_busy),
        .o_job_re (job_re),
        .o_job_im (job_im)
    );

    // Escape iteration.
    meb_iter u_iter (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (iter_start),
        .i_c_re  (r_c_re),
        .i_c_im  (r_c_im),
        .i_limit (r_limit),
        .o_res   (iter_res)
    );

    // Output register: holds a result until its transaction completes.
    always_comb begin
        n_out_valid = r_out_valid;
        if (out_load) begin
            n_out_valid = 1'b1;
        end else if (o_res.ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_col   <= r_col;
            r_out_row   <= r_row;
            r_out_count <= r_res_count;
            r_out_esc   <= r_res_esc;
        end
    end

    assign o_res.valid           = r_out_valid;
    assign o_res.out_col         = r_out_col;
    assign o_res.out_row         = r_out_row;
    assign o_res.iteration_count = r_out_count;
    assign o_res.escaped         = r_out_esc;

    // An accepted pixel always moves on to the divisor setup.
    a_accept_to_prep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_accept |=> (r_state == meb_pkg::S_PREP))
        else $error("accepted pixel did not enter divisor setup");

    // The divide ring runs only while the sequencer waits for it.
    a_div_in_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_busy |-> (r_state == meb_pkg::S_DIV))
        else $error("divide ring busy outside the divide phase");

    // The divide ring starts only from a load.
    a_div_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(div_busy) |-> $past(r_state == meb_pkg::S_LOAD))
        else $error("divide ring started without a load");

    // The iteration unit finishes only while the sequencer waits for it.
    a_iter_done_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        iter_res.done |-> (r_state == meb_pkg::S_ITER))
        else $error("iteration finished outside the iteration phase");

endmodule

FILE: test/mandelbrot_escape_time_core_tb.sv
// ----------------------------------------------------------------------------
// Mandelbrot escape-time core testbench
// Pixels are streamed in through a burst/gap driver while the result side
// stalls on its own pattern. Every accepted pixel is run through a fixed-point
// escape-time predictor with a private copy of the registers, and each result
// transaction is compared field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module mandelbrot_escape_time_core_tb;

    localparam int IMG_W           = meb_pkg::DEF_WIDTH;
    localparam int IMG_H           = meb_pkg::DEF_HEIGHT;
    localparam int COORD_MAX       = (1 << meb_pkg::COORD_W) - 1;
    localparam int CNT_MAX         = (1 << meb_pkg::CNT_W) - 1;
    localparam int FIX_ONE         = 1 << meb_pkg::FRAC_W;
    localparam longint ESCAPE_LEVEL = longint'(4) << meb_pkg::FRAC_W;
    localparam longint PLANE_MAX   = 64'sd2147483647;
    localparam longint PLANE_MIN   = -PLANE_MAX - 1;
    localparam int SETTLE_CYCLES   = 8;
    localparam int HOLD_CYCLES     = 3000;
    localparam int WATCHDOG_CYCLES = 20000;
    localparam int RANDOM_PHASES   = 14;
    localparam int HOLD_PHASE      = 2;
    localparam int DEEP_PHASE      = 5;

    typedef struct packed {
        logic [meb_pkg::COORD_W-1:0] col;
        logic [meb_pkg::COORD_W-1:0] row;
    } t_pixel;

    typedef struct packed {
        logic [meb_pkg::COORD_W-1:0] col;
        logic [meb_pkg::COORD_W-1:0] row;
        logic [meb_pkg::CNT_W-1:0]   count;
        logic                        escaped;
    } t_escape_result;

    typedef enum logic [1:0] {
        RX_ALWAYS,
        RX_COIN,
        RX_PERIODIC
    } t_rx_pattern;

    typedef enum logic {
        TX_STREAM,
        TX_BURSTS
    } t_tx_pattern;

    logic clk = 1'b0;
    logic rst_n;

    logic                          cfg_valid;
    logic [meb_pkg::CFG_IDX_W-1:0] cfg_index;
    logic [meb_pkg::DATA_W-1:0]    cfg_data;
    logic                          cfg_ready;

    meb_pix_if pix_ch ();
    meb_res_if res_ch ();

    // Register copies used by the predictor.
    logic [meb_pkg::ZOOM_W-1:0]        zoom_reg     = meb_pkg::ZOOM_RESET;
    logic signed [meb_pkg::DATA_W-1:0] shift_re_reg = '0;
    logic signed [meb_pkg::DATA_W-1:0] shift_im_reg = '0;
    logic [meb_pkg::CNT_W-1:0]         limit_reg    = meb_pkg::LIMIT_RESET;

    t_pixel         pending_pixels[$];
    t_escape_result expected_results[$];

    bit          pix_fire      = 1'b0;
    int          burst_left    = 1;
    int          gap_left      = 0;
    int          hold_request  = 0;
    int          hold_left     = 0;
    int          rx_tick       = 0;
    int          stuck_cycles  = 0;
    int          mismatch_count = 0;
    t_rx_pattern rx_mode       = RX_COIN;
    t_tx_pattern tx_mode       = TX_BURSTS;

    mandelbrot_escape_time_core #(
        .WIDTH  (IMG_W),
        .HEIGHT (IMG_H)
    ) uut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_pix       (pix_ch),
        .o_res       (res_ch),
        .i_cfg_valid (cfg_valid),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data),
        .o_cfg_ready (cfg_ready)
    );

    always #10 clk = ~clk;

    // Clamp a wide value to the signed Q4.28 range.
    function automatic logic signed [meb_pkg::DATA_W-1:0] clamp_plane(input longint v);
        if (v > PLANE_MAX) begin
            return PLANE_MAX[meb_pkg::DATA_W-1:0];
        end else if (v < PLANE_MIN) begin
            return PLANE_MIN[meb_pkg::DATA_W-1:0];
        end
        return v[meb_pkg::DATA_W-1:0];
    endfunction

    // Map a pixel position on one axis to the plane, then add the view offset.
    function automatic logic signed [meb_pkg::DATA_W-1:0] plane_coord(
        input logic [meb_pkg::COORD_W-1:0]        pos,
        input int                                 size,
        input logic signed [meb_pkg::DATA_W-1:0]  shift
    );
        longint     diff;
        longint     val;
        logic [63:0] mag;
        logic [63:0] den;
        logic [63:0] quo;
        diff = longint'(pos) - longint'(size / 2);
        mag  = (diff < 0) ? 64'(-diff) : 64'(diff);
        mag  = mag << meb_pkg::MAP_SHIFT;
        // A zero zoom behaves as the smallest nonzero zoom.
        den  = ((zoom_reg == '0) ? 64'd1 : 64'(zoom_reg)) * 64'(size);
        quo  = mag / den;
        if (diff < 0) begin
            val = (quo >= 64'h8000_0000) ? PLANE_MIN : -longint'(quo);
        end else begin
            val = (quo > 64'h7FFF_FFFF) ? PLANE_MAX : longint'(quo);
        end
        return clamp_plane(val + longint'(shift));
    endfunction

    // Escape-time count for one pixel under the current register copies.
    function automatic t_escape_result predict_escape(input logic [meb_pkg::COORD_W-1:0] col,
                                                      input logic [meb_pkg::COORD_W-1:0] row);
        t_escape_result                    res;
        logic signed [meb_pkg::DATA_W-1:0] c_re;
        logic signed [meb_pkg::DATA_W-1:0] c_im;
        logic signed [meb_pkg::DATA_W-1:0] x;
        logic signed [meb_pkg::DATA_W-1:0] y;
        longint                            xx;
        longint                            yy;
        longint                            xy;
        logic [meb_pkg::CNT_W-1:0]         n;
        bit                                running;
        c_re    = plane_coord(col, IMG_W, shift_re_reg);
        c_im    = plane_coord(row, IMG_H, shift_im_reg);
        x       = '0;
        y       = '0;
        n       = '0;
        running = 1'b1;
        while (running) begin
            xx = (longint'(x) * longint'(x)) >>> meb_pkg::FRAC_W;
            yy = (longint'(y) * longint'(y)) >>> meb_pkg::FRAC_W;
            if (xx + yy > ESCAPE_LEVEL || n >= limit_reg) begin
                running = 1'b0;
            end else begin
                xy = (longint'(x) * longint'(y)) >>> meb_pkg::FRAC_W;
                x  = clamp_plane(xx - yy + longint'(c_re));
                y  = clamp_plane(2 * xy + longint'(c_im));
                n++;
            end
        end
        res.col     = col;
        res.row     = row;
        res.count   = n;
        res.escaped = (n < limit_reg);
        return res;
    endfunction

    function automatic void add_pixel(input int col, input int row);
        pending_pixels.push_back({meb_pkg::COORD_W'(col), meb_pkg::COORD_W'(row)});
    endfunction

    // Mostly uniform over the picture, with a share clustered around the center.
    task automatic queue_pixels(input int n);
        repeat (n) begin
            if ($urandom_range(0, 3) == 0) begin
                add_pixel(IMG_W / 2 - 16 + int'($urandom_range(0, 31)),
                          IMG_H / 2 - 16 + int'($urandom_range(0, 31)));
            end else begin
                add_pixel(int'($urandom_range(0, COORD_MAX)),
                          int'($urandom_range(0, COORD_MAX)));
            end
        end
    endtask

    // One register write transaction; the copy is updated once it is accepted.
    task automatic write_reg(input logic [meb_pkg::CFG_IDX_W-1:0] idx,
                             input logic [meb_pkg::DATA_W-1:0]    data);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        case (idx)
            meb_pkg::CFG_ZOOM:     zoom_reg     = data;
            meb_pkg::CFG_SHIFT_RE: shift_re_reg = data;
            meb_pkg::CFG_SHIFT_IM: shift_im_reg = data;
            meb_pkg::CFG_LIMIT:    limit_reg    = data[meb_pkg::CNT_W-1:0];
            default:      ;
        endcase
    endtask

    // Write all four registers plus one unmapped index, with junk above the limit bits.
    task automatic program_regs(input logic [meb_pkg::ZOOM_W-1:0]        zoom,
                                input logic signed [meb_pkg::DATA_W-1:0] s_re,
                                input logic signed [meb_pkg::DATA_W-1:0] s_im,
                                input logic [meb_pkg::CNT_W-1:0]         lim);
        write_reg(meb_pkg::CFG_ZOOM, zoom);
        write_reg(meb_pkg::CFG_SHIFT_RE, s_re);
        write_reg(meb_pkg::CFG_SHIFT_IM, s_im);
        write_reg(meb_pkg::CFG_LIMIT, ($urandom << meb_pkg::CNT_W) | meb_pkg::DATA_W'(lim));
        write_reg(meb_pkg::CFG_IDX_W'($urandom_range(meb_pkg::CFG_LIMIT + 1,
                                                     (1 << meb_pkg::CFG_IDX_W) - 1)),
                  $urandom);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // Wait until every queued pixel has gone through and its result has come back.
    task automatic wait_drained();
        @(posedge clk);
        while (pending_pixels.size() != 0 || pix_ch.valid || expected_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Pixel driver: random-length bursts with random gaps, or no gaps in stream mode.
    always @(negedge clk) begin : pixel_driver
        t_pixel nxt;
        logic   offer;
        offer = pix_ch.valid && !pix_fire;
        if (rst_n && !offer) begin
            if (gap_left > 0) begin
                gap_left--;
            end else if (pending_pixels.size() != 0) begin
                nxt = pending_pixels.pop_front();
                pix_ch.pixel_col <= nxt.col;
                pix_ch.pixel_row <= nxt.row;
                offer = 1'b1;
                if (burst_left > 1) begin
                    burst_left--;
                end else begin
                    burst_left = $urandom_range(1, 6);
                    gap_left   = (tx_mode == TX_STREAM) ? 0 : $urandom_range(0, 40);
                end
            end
        end
        pix_ch.valid <= offer;
    end

    // Result sink: ready follows the current pattern unless a long hold is running.
    always @(negedge clk) begin : result_sink
        logic take;
        if (hold_request != 0) begin
            hold_left    = hold_request;
            hold_request = 0;
        end
        rx_tick++;
        if (!rst_n || hold_left != 0) begin
            take = 1'b0;
        end else begin
            case (rx_mode)
                RX_ALWAYS: take = 1'b1;
                RX_COIN:   take = 1'($urandom_range(0, 1));
                default:   take = (rx_tick % 7) < 2;
            endcase
        end
        if (hold_left != 0) hold_left--;
        res_ch.ready <= take;
    end

    // Monitor: predict on each accepted pixel, check each accepted result.
    always @(posedge clk) begin : result_check
        t_escape_result want;
        logic           res_fire;
        logic           cfg_fire;
        pix_fire = rst_n && pix_ch.valid && pix_ch.ready;
        res_fire = rst_n && res_ch.valid && res_ch.ready;
        cfg_fire = rst_n && cfg_valid && cfg_ready;
        if (pix_fire) begin
            expected_results.push_back(predict_escape(pix_ch.pixel_col, pix_ch.pixel_row));
        end
        if (res_fire) begin
            if (expected_results.size() == 0) begin
                $error("result for pixel (%0d, %0d) with no pixel outstanding",
                       res_ch.out_col, res_ch.out_row);
                mismatch_count++;
            end else begin
                want = expected_results.pop_front();
                if (res_ch.out_col !== want.col) begin
                    $error("out_col: expected %0d, got %0d", want.col, res_ch.out_col);
                    mismatch_count++;
                end
                if (res_ch.out_row !== want.row) begin
                    $error("out_row: expected %0d, got %0d", want.row, res_ch.out_row);
                    mismatch_count++;
                end
                if (res_ch.iteration_count !== want.count) begin
                    $error("iteration_count: expected %0d, got %0d",
                           want.count, res_ch.iteration_count);
                    mismatch_count++;
                end
                if (res_ch.escaped !== want.escaped) begin
                    $error("escaped: expected %0d, got %0d", want.escaped, res_ch.escaped);
                    mismatch_count++;
                end
            end
        end
        // Watchdog on cycles without any transaction.
        if (pix_fire || res_fire || cfg_fire) begin
            stuck_cycles = 0;
        end else begin
            stuck_cycles++;
        end
        if (stuck_cycles >= WATCHDOG_CYCLES) begin
            $display("tb: failure");
            $finish;
        end
    end

    initial begin : stimulus
        int                                phase;
        logic [meb_pkg::CNT_W-1:0]         lim;
        logic [meb_pkg::ZOOM_W-1:0]        zoom;
        logic signed [meb_pkg::DATA_W-1:0] s_re;
        logic signed [meb_pkg::DATA_W-1:0] s_im;
        rst_n            = 1'b0;
        cfg_valid        = 1'b0;
        cfg_index        = '0;
        cfg_data         = '0;
        pix_ch.valid     = 1'b0;
        pix_ch.pixel_col = '0;
        pix_ch.pixel_row = '0;
        res_ch.ready     = 1'b0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Reset register values: corners, center, axis points and bit patterns.
        add_pixel(0, 0);
        add_pixel(COORD_MAX, COORD_MAX);
        add_pixel(0, COORD_MAX);
        add_pixel(COORD_MAX, 0);
        add_pixel(IMG_W / 2, IMG_H / 2);
        add_pixel(IMG_W / 2 - 1, IMG_H / 2 - 1);
        add_pixel(IMG_W / 2 + 1, IMG_H / 2 + 1);
        add_pixel(0, IMG_H / 2);
        add_pixel(COORD_MAX, IMG_H / 2);
        add_pixel(3 * IMG_W / 4, IMG_H / 2);
        add_pixel('h155, 'h2AA);
        add_pixel('h2AA, 'h155);
        add_pixel(5 * IMG_W / 8, 3 * IMG_H / 8);
        wait_drained();

        // A zero limit runs no iteration at all.
        program_regs(meb_pkg::ZOOM_RESET, '0, '0, '0);
        add_pixel(IMG_W / 2, IMG_H / 2);
        queue_pixels(3);
        wait_drained();

        // Zero zoom with extreme offsets: mapping saturates on both sides.
        program_regs('0, meb_pkg::DATA_MAX, meb_pkg::DATA_MIN, meb_pkg::CNT_W'(1));
        add_pixel(0, 0);
        add_pixel(COORD_MAX, COORD_MAX);
        add_pixel(IMG_W / 2, IMG_H / 2);
        add_pixel(IMG_W / 2 + 1, IMG_H / 2 - 1);
        wait_drained();

        // Deepest zoom near the cardioid neck at the largest limit.
        program_regs('1, -(3 * FIX_ONE / 4), FIX_ONE / 10, meb_pkg::CNT_W'(CNT_MAX));
        add_pixel(IMG_W / 2, IMG_H / 2);
        add_pixel(0, 0);
        add_pixel(COORD_MAX, COORD_MAX);
        wait_drained();

        // Smallest nonzero zoom with the offsets swapped.
        program_regs(1, meb_pkg::DATA_MIN, meb_pkg::DATA_MAX, meb_pkg::CNT_W'(CNT_MAX));
        add_pixel(0, COORD_MAX);
        add_pixel(IMG_W / 2, IMG_H / 2);
        wait_drained();

        // Random register settings, each followed by a batch of pixels.
        for (phase = 0; phase < RANDOM_PHASES; phase++) begin
            if (phase == DEEP_PHASE) begin
                lim = meb_pkg::CNT_W'(CNT_MAX);
            end else if ($urandom_range(0, 11) == 0) begin
                lim = '0;
            end else begin
                lim = meb_pkg::CNT_W'($urandom_range(1, 120));
            end
            case ($urandom_range(0, 3))
                0:       zoom = meb_pkg::ZOOM_RESET;
                1:       zoom = $urandom_range(1, 32'h0000_FFFF);
                2:       zoom = $urandom_range(32'h0001_0000, 32'h0100_0000);
                default: zoom = $urandom;
            endcase
            // Views centered on interesting parts of the set boundary.
            case ($urandom_range(0, 5))
                0: begin
                    s_re = -(3 * FIX_ONE / 4);
                    s_im = FIX_ONE / 10;
                end
                1: begin
                    s_re = -(FIX_ONE / 10);
                    s_im = FIX_ONE / 20 * 13;
                end
                2: begin
                    s_re = 3 * FIX_ONE / 10;
                    s_im = FIX_ONE / 50;
                end
                3: begin
                    s_re = -(5 * FIX_ONE / 4);
                    s_im = FIX_ONE / 50;
                end
                4: begin
                    s_re = '0;
                    s_im = '0;
                end
                default: begin
                    s_re = $urandom;
                    s_im = $urandom;
                end
            endcase
            s_re = s_re + int'($urandom_range(0, 1 << 20)) - (1 << 19);
            s_im = s_im + int'($urandom_range(0, 1 << 20)) - (1 << 19);

            if (phase == 0) begin
                rx_mode = RX_ALWAYS;
                tx_mode = TX_STREAM;
            end else if (phase == HOLD_PHASE) begin
                rx_mode = RX_COIN;
                tx_mode = TX_STREAM;
            end else begin
                rx_mode = t_rx_pattern'($urandom_range(0, 2));
                tx_mode = t_tx_pattern'($urandom_range(0, 1));
            end

            program_regs(zoom, s_re, s_im, lim);
            queue_pixels((lim == meb_pkg::CNT_W'(CNT_MAX)) ? 8 : 42);
            // Stall the result side long enough for the core to back up.
            if (phase == HOLD_PHASE) hold_request = HOLD_CYCLES;
            wait_drained();
        end

        repeat (100) @(posedge clk);
        if (mismatch_count == 0 && expected_results.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
